// ===== src/rau_pkg.sv =====
// Rational arithmetic unit: shared types, codes and constants.
// No dependencies.
package rau_pkg;

  localparam int unsigned WidthDefault = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_DIVZ = 2'd2,
    ST_OVF  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]   cmd;
    logic [31:0]  a_num;
    logic [31:0]  a_den;
    logic [31:0]  b_num;
    logic [31:0]  b_den;
  } in_item_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  status;
  } out_item_t;

  // Back-end state machine
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_GCD,
    BS_DIVN,
    BS_DIVD,
    BS_DONE
  } bstate_t;

endpackage

// ===== src/rau_front.sv =====
// Rational arithmetic unit front end: checks, cross products, sign fix-up.
// Depends on rau_pkg.
module rau_front #(
  parameter int unsigned WIDTH = rau_pkg::WidthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rau_pkg::in_item_t  in_item,
  // to queue
  output logic               f_valid,
  input  logic               f_ready,
  output logic               f_neg,
  output logic [WIDTH-1:0]   f_mn,
  output logic [WIDTH-1:0]   f_md,
  output logic [1:0]         f_status
);
  import rau_pkg::*;

  localparam int unsigned PW = 64;

  // stage 0: registered input
  logic             s0_v_r;
  in_item_t         s0_r;
  // stage 1: products
  logic             s1_v_r;
  logic [1:0]       s1_st_r;
  logic             s1_ok_r;
  logic [1:0]       s1_cmd_r;
  logic signed [PW-1:0] p1_r, p2_r, pd_r;
  // stage 2 output
  logic             s2_v_r;
  logic             s2_neg_r;
  logic [WIDTH-1:0] s2_mn_r, s2_md_r;
  logic [1:0]       s2_st_r;

  logic stall2, adv1, adv0;
  assign stall2 = s2_v_r && !f_ready;
  assign adv1   = !stall2;
  assign adv0   = !(s1_v_r && !adv1);
  // stage 0 only loads when it can also hand its item on
  assign in_full = !adv0;

  function automatic logic fits(input logic signed [PW+1:0] v);
    logic signed [PW+1:0] hi;
    hi = (PW+2)'((66'sd1 <<< (WIDTH-1)) - 66'sd1);
    return (v <= hi) && (v >= -hi - 66'sd1);
  endfunction

  // stage 0 -> 1: range checks and products
  logic signed [PW-1:0] an, ad, bn, bd;
  logic signed [PW-1:0] m1a, m1b, m2a, m2b;
  logic [1:0] st0;
  logic ok0;
  always_comb begin
    an = PW'(signed'(s0_r.a_num));
    ad = PW'(signed'(s0_r.a_den));
    bn = PW'(signed'(s0_r.b_num));
    bd = PW'(signed'(s0_r.b_den));
    st0 = ST_OK;
    if (ad == 0 || bd == 0) st0 = ST_ZDEN;
    else if (s0_r.cmd == CMD_DIV && bn == 0) st0 = ST_DIVZ;
    ok0 = fits((PW+2)'(an)) && fits((PW+2)'(ad)) && fits((PW+2)'(bn)) &&
          fits((PW+2)'(bd));
    m1a = an; m1b = bd; m2a = bn; m2b = ad;
    if (s0_r.cmd == CMD_MUL) begin
      m1b = bn; m2a = ad; m2b = bd;
    end else if (s0_r.cmd == CMD_DIV) begin
      m2a = ad; m2b = bn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (adv0) s0_v_r <= in_push && !in_full;
      if (adv0) s1_v_r <= s0_v_r;
      if (adv1) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_push && !in_full) s0_r <= in_item;
    if (adv0) begin
      s1_st_r  <= st0;
      s1_ok_r  <= ok0;
      s1_cmd_r <= s0_r.cmd;
      p1_r <= m1a * m1b;
      p2_r <= m2a * m2b;
      pd_r <= ad * bd;
    end
  end

  // stage 1 -> 2: sum, sign fix-up, magnitudes
  logic signed [PW+1:0] t2, num, den, sum;
  logic ok1, negd;
  logic [1:0] st1;
  always_comb begin
    ok1 = s1_ok_r;
    t2  = (PW+2)'(p2_r);
    num = (PW+2)'(p1_r);
    den = (PW+2)'(pd_r);
    if (s1_cmd_r == CMD_ADD || s1_cmd_r == CMD_SUB) begin
      ok1 = ok1 && fits(num) && fits(t2) && fits(den);
      if (s1_cmd_r == CMD_SUB) t2 = -t2;
      ok1 = ok1 && fits(t2);
      sum = num + t2;
      ok1 = ok1 && fits(sum);
      num = sum;
    end else begin
      sum = '0;
      ok1 = ok1 && fits(num) && fits(t2);
      den = t2;
    end
    negd = den < 0;
    if (negd) begin
      num = -num;
      den = -den;
      ok1 = ok1 && fits(num) && fits(den);
    end
    st1 = s1_st_r;
    if (st1 == ST_OK && !ok1) st1 = ST_OVF;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_st_r  <= st1;
      s2_neg_r <= num < 0;
      s2_mn_r  <= (num < 0) ? WIDTH'(-num) : WIDTH'(num);
      s2_md_r  <= WIDTH'(den);
    end
  end

  assign f_valid  = s2_v_r;
  assign f_neg    = s2_neg_r;
  assign f_mn     = s2_mn_r;
  assign f_md     = s2_md_r;
  assign f_status = s2_st_r;
endmodule

// ===== src/rau_queue.sv =====
// Rational arithmetic unit: short queue between front and back ends.
// Depends on rau_pkg.
module rau_queue #(
  parameter int unsigned DW = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);
  import rau_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end
endmodule

// ===== src/rau_back.sv =====
// Rational arithmetic unit back end: binary GCD and two restoring divisions.
// Depends on rau_pkg.
module rau_back #(
  parameter int unsigned WIDTH = rau_pkg::WidthDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic                q_neg,
  input  logic [WIDTH-1:0]    q_mn,
  input  logic [WIDTH-1:0]    q_md,
  input  logic [1:0]          q_status,
  output logic                out_empty,
  input  logic                out_pop,
  output rau_pkg::out_item_t  out_item
);
  import rau_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH + 1);

  bstate_t state_r, state_nxt;
  logic             neg_r;
  logic [1:0]       st_r;
  logic [WIDTH-1:0] mn_r, md_r, x_r, y_r, g_r;
  logic [CW-1:0]    sh_r, cnt_r;
  logic [WIDTH-1:0] quo_r, rem_r, qn_r;
  out_item_t        res_r;
  logic             full_r;

  assign q_ready = state_r == BS_IDLE;
  assign out_empty = !full_r;
  assign out_item = res_r;

  // binary GCD step
  logic gcd_end;
  assign gcd_end = (x_r == '0) || (y_r == '0);

  // restoring division step: dividend shifted in from quo_r
  logic [WIDTH:0] trial;
  assign trial = {rem_r, quo_r[WIDTH-1]} - {1'b0, g_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: if (q_valid) state_nxt = (q_status == ST_OK) ? BS_GCD : BS_DONE;
      BS_GCD:  if (gcd_end) state_nxt = BS_DIVN;
      BS_DIVN: if (cnt_r == CW'(WIDTH - 1)) state_nxt = BS_DIVD;
      BS_DIVD: if (cnt_r == CW'(WIDTH - 1)) state_nxt = BS_DONE;
      BS_DONE: if (!full_r) state_nxt = BS_IDLE;
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BS_DONE && !full_r) full_r <= 1'b1;
      else if (out_pop && full_r) full_r <= 1'b0;
    end
  end

  // datapath
  logic [WIDTH-1:0] gfull, rn;
  logic big;
  always_comb begin
    gfull = (x_r | y_r) << sh_r;
    if (gfull == '0) gfull = WIDTH'(1);
    rn = neg_r ? -qn_r : qn_r;
    big = (quo_r > WIDTH'(32'h7FFF_FFFF)) ||
          (qn_r > (neg_r ? WIDTH'(33'h8000_0000) : WIDTH'(32'h7FFF_FFFF)));
    if (WIDTH <= 32) big = 1'b0;
  end

  always_ff @(posedge clk) begin
    unique case (state_r) inside
      BS_IDLE: begin
        neg_r <= q_neg;
        st_r  <= q_status;
        mn_r  <= q_mn;
        md_r  <= q_md;
        x_r   <= q_mn;
        y_r   <= q_md;
        sh_r  <= '0;
      end
      BS_GCD: begin
        if (gcd_end) begin
          g_r   <= gfull;
          cnt_r <= '0;
          quo_r <= mn_r;
          rem_r <= '0;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1; y_r <= y_r >> 1; sh_r <= sh_r + 1'b1;
        end else if (!x_r[0]) x_r <= x_r >> 1;
        else if (!y_r[0]) y_r <= y_r >> 1;
        else if (x_r >= y_r) x_r <= (x_r - y_r) >> 1;
        else y_r <= (y_r - x_r) >> 1;
      end
      BS_DIVN, BS_DIVD: begin
        if (state_r == BS_DIVN && cnt_r == CW'(WIDTH - 1)) begin
          // numerator finished: keep its quotient, start on the denominator
          cnt_r <= '0;
          qn_r  <= {quo_r[WIDTH-2:0], !trial[WIDTH]};
          quo_r <= md_r;
          rem_r <= '0;
        end else begin
          if (!trial[WIDTH]) rem_r <= trial[WIDTH-1:0];
          else rem_r <= {rem_r[WIDTH-2:0], quo_r[WIDTH-1]};
          quo_r <= {quo_r[WIDTH-2:0], !trial[WIDTH]};
          cnt_r <= (cnt_r == CW'(WIDTH - 1)) ? '0 : cnt_r + 1'b1;
        end
      end
      BS_DONE: begin
        if (!full_r) begin
          if (st_r != ST_OK || big) begin
            res_r.res_num <= '0;
            res_r.res_den <= '0;
            res_r.status  <= (st_r != ST_OK) ? st_r : ST_OVF;
          end else begin
            res_r.res_num <= 32'(signed'(rn));
            res_r.res_den <= 31'(quo_r);
            res_r.status  <= ST_OK;
          end
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== src/rational_arithmetic_unit.sv =====
// Rational arithmetic unit top level: front end, queue, GCD back end.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
//
//  channel | ports                     | handshake
//  input   | in_push, in_full, in_item | taken on push && !full
//  result  | out_pop, out_empty, out_item | taken on pop && !empty
//
// The front end is a three-stage pipeline and takes an item a cycle unless the queue stalls it.
// The back end holds one item: a binary GCD, then two restoring divisions
// by the GCD; it takes no new item until it is back in idle.
// Items with an error status skip the back-end loops.
// Reset is synchronous, active low; it empties the queue and the result slot.
// A full result slot stalls the back end, then the queue, then the front end.
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = rau_pkg::WidthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rau_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output rau_pkg::out_item_t out_item
);
  import rau_pkg::*;

  localparam int unsigned QW = 2*WIDTH + 3;

  logic f_valid, f_ready, f_neg, q_valid, q_ready;
  logic [WIDTH-1:0] f_mn, f_md;
  logic [1:0] f_status;
  logic [QW-1:0] q_data;

  rau_front #(.WIDTH(WIDTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .f_valid, .f_ready, .f_neg, .f_mn, .f_md, .f_status
  );

  rau_queue #(.DW(QW), .DEPTH(2)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready),
    .wr_data({f_neg, f_mn, f_md, f_status}),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk, .rst_n,
    .q_valid, .q_ready,
    .q_neg(q_data[QW-1]),
    .q_mn(q_data[QW-2 -: WIDTH]),
    .q_md(q_data[WIDTH+1 -: WIDTH]),
    .q_status(q_data[1:0]),
    .out_empty, .out_pop, .out_item
  );
endmodule
